// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every enabled clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at an enabled clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/rgef_pkg.sv =====
`default_nettype none
package rgef_pkg;

  localparam int PIX_W     = 8;
  localparam int MODE_W    = 3;
  localparam int THR_W     = 8;
  localparam int IMG_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [MODE_W-1:0] mode_t;

  // mode codes
  localparam mode_t MODE_COPY  = 3'd0;
  localparam mode_t MODE_RED   = 3'd1;
  localparam mode_t MODE_GREEN = 3'd2;
  localparam mode_t MODE_BLUE  = 3'd3;
  localparam mode_t MODE_LUMA  = 3'd4;
  localparam mode_t MODE_VEDGE = 3'd5;
  localparam mode_t MODE_HEDGE = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd2;

  localparam mode_t              MODE_RST  = MODE_COPY;
  localparam logic [THR_W-1:0]   THR_RST   = 8'd25;
  localparam logic [IMG_W-1:0]   WIDTH_RST = 11'd640;

  // decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = 2;
  localparam int QC_W    = 3;

  // per-channel luma weight tables, floor(v * coef / 10000)
  typedef pix_t lut_t [256];

  function automatic lut_t build_lut(input int unsigned coef);
    lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = PIX_W'((i * coef) / 10000);
    end
    return t;
  endfunction

  localparam lut_t RED_LUT   = build_lut(2126);
  localparam lut_t GREEN_LUT = build_lut(7152);
  localparam lut_t BLUE_LUT  = build_lut(722);

  // sum peaks at 254, so 8 bits hold it
  function automatic pix_t luma_of(input pix_t r, input pix_t g, input pix_t b);
    logic [PIX_W+1:0] s;
    s = (PIX_W+2)'(RED_LUT[r]) + (PIX_W+2)'(GREEN_LUT[g]) + (PIX_W+2)'(BLUE_LUT[b]);
    return s[PIX_W-1:0];
  endfunction

  // classified pixel handed from front to back
  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t luma;
    pix_t nb_luma;   // left or upper neighbor luma
    logic no_nb;     // first column / first row: no neighbor
  } item_t;

endpackage
`default_nettype wire

// ===== sv/rgef_ram.sv =====
`default_nettype none
module rgef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and write of one address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rgef_front.sv =====
`default_nettype none
module rgef_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire rgef_pkg::pix_t         in_red,
  input  wire rgef_pkg::pix_t         in_green,
  input  wire rgef_pkg::pix_t         in_blue,
  input  wire logic                   in_frame_start,
  input  wire rgef_pkg::mode_t        mode,
  input  wire logic [rgef_pkg::IMG_W-1:0] image_width,
  output logic                        fq_valid,
  input  wire logic                   fq_full,
  output rgef_pkg::item_t             fq_item
);
  import rgef_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > IMG_W) ? CW + 1 : IMG_W;

  logic          accept;
  logic [CW-1:0] col_cur;
  logic          fr_cur;
  pix_t          luma;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] col_inc;
  pix_t          above;

  logic [CW-1:0] col_r, col_nxt;
  logic          first_row_r, first_row_nxt;
  pix_t          left_luma_r;
  logic          s1_valid_r, s1_valid_nxt;
  item_t         s1_item_r;

  assign in_full = s1_valid_r && fq_full;
  assign accept  = in_push && !in_full;

  assign col_cur = in_frame_start ? '0 : col_r;
  assign fr_cur  = in_frame_start || first_row_r;
  assign luma    = luma_of(in_red, in_green, in_blue);

  always_comb begin
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
  end

  assign col_inc = EW'(col_cur) + EW'(1);

  always_comb begin
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt       = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_nxt       = col_inc[CW-1:0];
        first_row_nxt = fr_cur;
      end
    end
  end

  assign s1_valid_nxt = accept || (s1_valid_r && fq_full);

  // line store: luma of the previous row by column
  rgef_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cur),
    .wdata (luma),
    .re    (accept),
    .raddr (col_cur),
    .rdata (above)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      left_luma_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (accept) begin
        left_luma_r <= luma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.red     <= in_red;
      s1_item_r.green   <= in_green;
      s1_item_r.blue    <= in_blue;
      s1_item_r.luma    <= luma;
      s1_item_r.nb_luma <= left_luma_r;
      s1_item_r.no_nb   <= (mode == MODE_HEDGE) ? fr_cur : (col_cur == '0);
    end
  end

  // upper neighbor comes from the line store's registered read, in the cycle after accept
  always_comb begin
    fq_item = s1_item_r;
    if (mode == MODE_HEDGE) begin
      fq_item.nb_luma = above;
    end
  end

  assign fq_valid = s1_valid_r;

endmodule
`default_nettype wire

// ===== sv/rgef_queue.sv =====
`default_nettype none
module rgef_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_push,
  output logic                 q_full,
  input  wire rgef_pkg::item_t q_wdata,
  input  wire logic            q_pop,
  output logic                 q_empty,
  output rgef_pkg::item_t      q_head
);
  import rgef_pkg::*;

  item_t             mem_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == QC_W'(Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rgef_back.sv =====
`default_nettype none
module rgef_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rgef_pkg::mode_t            mode,
  input  wire logic [rgef_pkg::THR_W-1:0] edge_threshold,
  input  wire logic                       q_empty,
  input  wire rgef_pkg::item_t            q_head,
  output logic                            q_pop,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output rgef_pkg::pix_t                  out_red,
  output rgef_pkg::pix_t                  out_green,
  output rgef_pkg::pix_t                  out_blue
);
  import rgef_pkg::*;

  logic  load;
  pix_t  diff;
  pix_t  edge_px;
  pix_t  r_nxt, g_nxt, b_nxt;
  logic  out_valid_r;
  pix_t  out_red_r, out_green_r, out_blue_r;

  assign load  = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = load;

  assign diff    = (q_head.luma >= q_head.nb_luma) ? q_head.luma - q_head.nb_luma
                                                   : q_head.nb_luma - q_head.luma;
  assign edge_px = (q_head.no_nb || diff < edge_threshold) ? 8'hFF : 8'h00;

  always_comb begin
    r_nxt = q_head.red;
    g_nxt = q_head.green;
    b_nxt = q_head.blue;
    case (mode)
      MODE_RED: begin
        g_nxt = q_head.red;
        b_nxt = q_head.red;
      end
      MODE_GREEN: begin
        r_nxt = q_head.green;
        b_nxt = q_head.green;
      end
      MODE_BLUE: begin
        r_nxt = q_head.blue;
        g_nxt = q_head.blue;
      end
      MODE_LUMA: begin
        r_nxt = q_head.luma;
        g_nxt = q_head.luma;
        b_nxt = q_head.luma;
      end
      MODE_VEDGE, MODE_HEDGE: begin
        r_nxt = edge_px;
        g_nxt = edge_px;
        b_nxt = edge_px;
      end
      default: begin
        // copy, also the unused code
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red_r   <= r_nxt;
      out_green_r <= g_nxt;
      out_blue_r  <= b_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule
`default_nettype wire

// ===== sv/rgb_gray_and_edge_filter_unit.sv =====
// Channel  Dir  Handshake        Beat payload
// input    in   push / full      in_red, in_green, in_blue, in_frame_start
// result   out  empty / pop      out_red, out_green, out_blue
// config   in   cfg_we           cfg_idx, cfg_wdata
//
// One beat per clock each way while full is low and pop keeps up; a pixel
// reaches the result ports via the stage reg, the queue and the output reg.
// The line store takes one read and one write per pixel, so it never limits rate.
// full rises only when the front stage holds a pixel and the queue is full.
// Reset (rst_n low, synchronous) clears control and config; the line
// store is not cleared, its entries fill as the first row passes.
`default_nettype none
`include "assert_macros.svh"
module rgb_gray_and_edge_filter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               push,
  output logic                                    full,
  input  wire rgef_pkg::pix_t                     in_red,
  input  wire rgef_pkg::pix_t                     in_green,
  input  wire rgef_pkg::pix_t                     in_blue,
  input  wire logic                               in_frame_start,
  // result channel
  output logic                                    empty,
  input  wire logic                               pop,
  output rgef_pkg::pix_t                          out_red,
  output rgef_pkg::pix_t                          out_green,
  output rgef_pkg::pix_t                          out_blue,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [rgef_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [rgef_pkg::CFG_W-1:0]         cfg_wdata
);
  import rgef_pkg::*;

  mode_t              mode_r;
  logic [THR_W-1:0]   thr_r;
  logic [IMG_W-1:0]   width_r;

  logic               fq_valid;
  logic               q_full;
  item_t              fq_item;
  logic               q_empty;
  logic               q_pop;
  item_t              q_head;

  // config registers; index 3 has no register and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RST;
      thr_r   <= THR_RST;
      width_r <= WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_THR:   thr_r   <= cfg_wdata[THR_W-1:0];
        REG_WIDTH: width_r <= cfg_wdata[IMG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: column/row tracking, luma, line store, neighbor pick
  rgef_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (push),
    .in_full        (full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .mode           (mode_r),
    .image_width    (width_r),
    .fq_valid       (fq_valid),
    .fq_full        (q_full),
    .fq_item        (fq_item)
  );

  // decoupling queue between front and back
  rgef_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fq_valid),
    .q_full  (q_full),
    .q_wdata (fq_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // back: mode select, edge compare, output register
  rgef_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_r),
    .edge_threshold (thr_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_empty      (empty),
    .out_pop        (pop),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  // queue count can't be both zero and at depth
  `ASSERT_NEVER(a_q_flags, q_empty && q_full, "queue flags empty and full together")
  // an empty output reg picks up a waiting queue entry on the next edge
  `ASSERT_CLK(a_out_fill, (q_empty == 1'b0 && empty) |=> !empty, "output reg not refilled")
  // a front pixel that moves into the queue leaves it non-empty
  `ASSERT_CLK(a_stage_move, (fq_valid && !q_full) |=> !q_empty, "front pixel lost on move")

endmodule
`default_nettype wire
